[rtl/mrw_pkg.sv]
// Shared widths and verdict codes for the Miller-Rabin witness block.
package mrw_pkg;
   localparam int NUM_WIDTH = 32;
   localparam int WORD_WIDTH = 32;
   localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);
   localparam int WCNT_WIDTH = $clog2(WORD_WIDTH + 1);

   localparam logic [1:0] VERDICT_PRIME = 2'd0;
   localparam logic [1:0] VERDICT_COMPOSITE = 2'd1;
   localparam logic [1:0] VERDICT_INVALID = 2'd2;

   typedef logic [NUM_WIDTH-1:0] num_type;
endpackage

[rtl/mrw_cell.sv]
// One bit slice of the modular add-and-reduce accumulator.
module mrw_cell (
   input  logic clock,
   input  logic clr,
   input  logic en,
   input  logic y_bit,
   input  logic m_bit,
   input  logic carry_in,
   input  logic borrow_in,
   input  logic sel,
   output logic acc_bit,
   output logic carry_out,
   output logic borrow_out
);
   logic acc_ff, acc_in;
   logic s, d;

   always_comb begin
      s = acc_ff ^ y_bit ^ carry_in;
      carry_out = (acc_ff & y_bit) | (carry_in & (acc_ff ^ y_bit));
      d = s ^ m_bit ^ borrow_in;
      borrow_out = (~s & m_bit) | (~(s ^ m_bit) & borrow_in);
      if (clr) begin
         acc_in = 1'b0;
      end else if (en) begin
         acc_in = sel ? d : s;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc_bit = acc_ff;
endmodule

[rtl/mrw_row.sv]
// Row of bit cells: acc <= (acc + y) mod m, given acc and y below m.
module mrw_row import mrw_pkg::*; (
   input  logic    clock,
   input  logic    clr,
   input  logic    en,
   input  num_type y,
   input  num_type modulus,
   output num_type acc
);
   logic [NUM_WIDTH:0] carry;
   logic [NUM_WIDTH:0] borrow;
   logic sel;

   assign carry[0] = 1'b0;
   assign borrow[0] = 1'b0;
   // subtract when the sum overflowed or did not borrow
   assign sel = carry[NUM_WIDTH] | ~borrow[NUM_WIDTH];

   for (genvar i = 0; i < NUM_WIDTH; i++) begin : g_cell
      mrw_cell u_cell (
         .clock     (clock),
         .clr       (clr),
         .en        (en),
         .y_bit     (y[i]),
         .m_bit     (modulus[i]),
         .carry_in  (carry[i]),
         .borrow_in (borrow[i]),
         .sel       (sel),
         .acc_bit   (acc[i]),
         .carry_out (carry[i+1]),
         .borrow_out(borrow[i+1])
      );
   end
endmodule

[rtl/miller_rabin_witness_test_top.sv]
// n below 3 or even n gets its verdict straight from idle, without any modular work.
// A square and a multiply by the base each do one double and one add per multiplier bit through
// the single row of bit cells; the base reduction does the same per bit of the random word.
// One item at a time: busy stays high until the verdict strobe.
// Synchronous active-high reset returns the controller to idle and drops the strobe.
module miller_rabin_witness_test_top import mrw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_candidate,
   input  logic [31:0] req_random_word,
   output logic        rsp_valid,
   output logic [1:0]  rsp_verdict
);
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_RED_DBL  = 4'd1;
   localparam logic [3:0] ST_RED_ADD  = 4'd2;
   localparam logic [3:0] ST_BASE_INC = 4'd3;
   localparam logic [3:0] ST_FACTOR   = 4'd4;
   localparam logic [3:0] ST_NORM     = 4'd5;
   localparam logic [3:0] ST_POW_STEP = 4'd6;
   localparam logic [3:0] ST_FIN_STEP = 4'd7;
   localparam logic [3:0] ST_MUL_DBL  = 4'd8;
   localparam logic [3:0] ST_MUL_ADD  = 4'd9;
   localparam logic [3:0] ST_MUL_END  = 4'd10;

   localparam logic [1:0] OP_POW_SQ  = 2'd0;
   localparam logic [1:0] OP_POW_MUL = 2'd1;
   localparam logic [1:0] OP_FIN_SQ  = 2'd2;

   logic [3:0] state_ff, state_in;
   logic [1:0] op_ff, op_in;
   num_type n_ff, n_in, nm1_ff, nm1_in, base_ff, base_in, x_ff, x_in;
   num_type a_ff, a_in, b_ff, b_in, exp_ff, exp_in;
   logic [WORD_WIDTH-1:0] word_ff, word_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in, t_ff, t_in;
   logic [WCNT_WIDTH-1:0] wcnt_ff, wcnt_in;
   logic valid_ff, valid_in;
   logic [1:0] verdict_ff, verdict_in;

   logic row_clr, row_en;
   num_type row_y, row_mod, acc;
   num_type n_req;

   localparam num_type ONE = num_type'(1);

   mrw_row u_row (
      .clock  (clock),
      .clr    (row_clr),
      .en     (row_en),
      .y      (row_y),
      .modulus(row_mod),
      .acc    (acc)
   );

   assign n_req = req_candidate[NUM_WIDTH-1:0];

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      n_in = n_ff;
      nm1_in = nm1_ff;
      base_in = base_ff;
      x_in = x_ff;
      a_in = a_ff;
      b_in = b_ff;
      exp_in = exp_ff;
      word_in = word_ff;
      cnt_in = cnt_ff;
      t_in = t_ff;
      wcnt_in = wcnt_ff;
      valid_in = 1'b0;
      verdict_in = verdict_ff;
      row_clr = 1'b0;
      row_en = 1'b0;
      row_y = '0;
      row_mod = n_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in = n_req;
               nm1_in = n_req - ONE;
               exp_in = n_req - ONE;
               word_in = req_random_word;
               wcnt_in = WCNT_WIDTH'(WORD_WIDTH);
               t_in = '0;
               row_clr = 1'b1;
               if (n_req < num_type'(2)) begin
                  verdict_in = VERDICT_INVALID;
                  valid_in = 1'b1;
               end else if (n_req == num_type'(2)) begin
                  verdict_in = VERDICT_PRIME;
                  valid_in = 1'b1;
               end else if (!n_req[0]) begin
                  verdict_in = VERDICT_COMPOSITE;
                  valid_in = 1'b1;
               end else begin
                  state_in = ST_RED_DBL;
               end
            end
         end
         ST_RED_DBL: begin
            row_en = 1'b1;
            row_y = acc;
            row_mod = nm1_ff;
            state_in = ST_RED_ADD;
         end
         ST_RED_ADD: begin
            // shift in the next word bit, mod n-1
            row_en = 1'b1;
            row_y = num_type'(word_ff[WORD_WIDTH-1]);
            row_mod = nm1_ff;
            word_in = word_ff << 1;
            wcnt_in = wcnt_ff - 1'b1;
            state_in = (wcnt_ff == WCNT_WIDTH'(1)) ? ST_BASE_INC : ST_RED_DBL;
         end
         ST_BASE_INC: begin
            row_en = 1'b1;
            row_y = ONE;
            state_in = ST_FACTOR;
         end
         ST_FACTOR: begin
            base_in = acc;
            if (!exp_ff[0]) begin
               exp_in = exp_ff >> 1;
               t_in = t_ff + 1'b1;
            end else begin
               cnt_in = CNT_WIDTH'(NUM_WIDTH);
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            // drop leading zeros of u; the top one bit loads x with the base
            exp_in = exp_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (exp_ff[NUM_WIDTH-1]) begin
               x_in = base_ff;
               state_in = ST_POW_STEP;
            end
         end
         ST_POW_STEP: begin
            if (cnt_ff == '0) begin
               state_in = ST_FIN_STEP;
            end else begin
               a_in = x_ff;
               b_in = x_ff;
               op_in = OP_POW_SQ;
               cnt_in = cnt_ff;
               wcnt_in = WCNT_WIDTH'(NUM_WIDTH);
               row_clr = 1'b1;
               state_in = ST_MUL_DBL;
            end
         end
         ST_FIN_STEP: begin
            if (t_ff == '0) begin
               verdict_in = (x_ff != ONE) ? VERDICT_COMPOSITE : VERDICT_PRIME;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               a_in = x_ff;
               b_in = x_ff;
               op_in = OP_FIN_SQ;
               wcnt_in = WCNT_WIDTH'(NUM_WIDTH);
               row_clr = 1'b1;
               state_in = ST_MUL_DBL;
            end
         end
         ST_MUL_DBL: begin
            row_en = 1'b1;
            row_y = acc;
            state_in = ST_MUL_ADD;
         end
         ST_MUL_ADD: begin
            row_en = 1'b1;
            row_y = b_ff[NUM_WIDTH-1] ? a_ff : '0;
            b_in = b_ff << 1;
            wcnt_in = wcnt_ff - 1'b1;
            state_in = (wcnt_ff == WCNT_WIDTH'(1)) ? ST_MUL_END : ST_MUL_DBL;
         end
         ST_MUL_END: begin
            x_in = acc;
            case (op_ff)
               OP_POW_SQ: begin
                  if (exp_ff[NUM_WIDTH-1]) begin
                     a_in = acc;
                     b_in = base_ff;
                     op_in = OP_POW_MUL;
                     wcnt_in = WCNT_WIDTH'(NUM_WIDTH);
                     row_clr = 1'b1;
                     state_in = ST_MUL_DBL;
                  end else begin
                     exp_in = exp_ff << 1;
                     cnt_in = cnt_ff - 1'b1;
                     state_in = ST_POW_STEP;
                  end
               end
               OP_POW_MUL: begin
                  exp_in = exp_ff << 1;
                  cnt_in = cnt_ff - 1'b1;
                  state_in = ST_POW_STEP;
               end
               default: begin
                  // nontrivial square root of one proves n composite
                  if (acc == ONE && x_ff != ONE && x_ff != nm1_ff) begin
                     verdict_in = VERDICT_COMPOSITE;
                     valid_in = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     t_in = t_ff - 1'b1;
                     state_in = ST_FIN_STEP;
                  end
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      op_ff <= op_in;
      n_ff <= n_in;
      nm1_ff <= nm1_in;
      base_ff <= base_in;
      x_ff <= x_in;
      a_ff <= a_in;
      b_ff <= b_in;
      exp_ff <= exp_in;
      word_ff <= word_in;
      cnt_ff <= cnt_in;
      t_ff <= t_in;
      wcnt_ff <= wcnt_in;
      verdict_ff <= verdict_in;
   end

   assign busy = reset | (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_verdict = verdict_ff;
endmodule

[rtl/mrw_checker.sv]
// Port-level checks for the witness test block, bound to the top level.
module mrw_checker import mrw_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_verdict
);
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted item neither in work nor answered");

   // busy also follows reset, so skip the edge right after reset
   a_busy_done: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy dropped without a verdict");

   a_no_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("verdict strobe while busy");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict == VERDICT_PRIME || rsp_verdict == VERDICT_COMPOSITE ||
                     rsp_verdict == VERDICT_INVALID))
      else $error("undefined verdict code");
endmodule

bind miller_rabin_witness_test_top mrw_checker u_mrw_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_verdict(rsp_verdict)
);
